// ===== rtl/core/qlt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qlt_pkg;

  // Line capacity and token limit
  localparam int LINE_BYTES = 256;
  localparam int MAX_ARGS   = 8;

  localparam int CHARS_W = $clog2(LINE_BYTES);
  localparam int TOK_W   = $clog2(MAX_ARGS + 2);

  localparam logic [CHARS_W-1:0] CHAR_LIMIT = CHARS_W'(LINE_BYTES - 1);
  localparam logic [TOK_W-1:0]   TOK_MAX    = TOK_W'(MAX_ARGS);

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_PLAIN,
    PH_QUOTE,
    PH_BSLASH,
    PH_AFTERQ,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_TOK_END,
    KIND_LINE_END
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BLANK,
    ST_TOO_MANY,
    ST_UNTERM,
    ST_JUNK
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [3:0] idx;
    status_e    status;
    logic [3:0] argc;
    logic       name;
    logic       ovf;
    logic       last;
  } result_t;

  function automatic result_t mk_char(logic [7:0] c, logic [TOK_W-1:0] tok);
    result_t r;
    r      = '0;
    r.kind = KIND_CHAR;
    r.ch   = c;
    r.idx  = 4'(tok);
    return r;
  endfunction

  function automatic result_t mk_tok_end(logic [TOK_W-1:0] tok);
    result_t r;
    r      = '0;
    r.kind = KIND_TOK_END;
    r.idx  = 4'(tok);
    return r;
  endfunction

  function automatic result_t mk_line_end(status_e st, logic [3:0] argc, logic name,
                                          logic ovf);
    result_t r;
    r        = '0;
    r.kind   = KIND_LINE_END;
    r.status = st;
    r.argc   = argc;
    r.name   = name;
    r.ovf    = ovf;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qlt_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qlt_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      acc_i,
  input  wire logic [7:0]                byte_i,
  output qlt_pkg::result_t [1:0]         res_o,
  output logic [1:0]                     n_o
);

  qlt_pkg::phase_e                  phase_q, phase_d;
  logic [qlt_pkg::TOK_W-1:0]        tokens_q, tokens_d;
  logic [qlt_pkg::CHARS_W-1:0]      chars_q, chars_d;
  logic                             ovf_q, ovf_d;
  qlt_pkg::status_e                 err_q, err_d;

  logic is_lf, is_cr, is_ws, room, tok_end_view, qerr_view;

  assign is_lf = (byte_i == qlt_pkg::CH_LF);
  assign is_cr = (byte_i == qlt_pkg::CH_CR);
  assign is_ws = (byte_i == qlt_pkg::CH_SPACE) || (byte_i == qlt_pkg::CH_TAB);
  assign room  = (chars_q < qlt_pkg::CHAR_LIMIT);
  // what closing the view does from the current phase
  assign tok_end_view = (phase_q == qlt_pkg::PH_PLAIN) || (phase_q == qlt_pkg::PH_AFTERQ);
  assign qerr_view    = (phase_q == qlt_pkg::PH_QUOTE) || (phase_q == qlt_pkg::PH_BSLASH);

  // next state
  always_comb begin
    phase_d  = phase_q;
    tokens_d = tokens_q;
    chars_d  = chars_q;
    ovf_d    = ovf_q;
    err_d    = err_q;
    if (is_lf) begin
      phase_d  = qlt_pkg::PH_BETWEEN;
      tokens_d = '0;
      chars_d  = '0;
      ovf_d    = 1'b0;
      err_d    = qlt_pkg::ST_OK;
    end else if (!is_cr) begin
      if (room) begin
        chars_d = chars_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      if ((room && byte_i == qlt_pkg::CH_NUL) ||
          (!room && phase_q != qlt_pkg::PH_DONE)) begin
        if (tok_end_view) begin
          tokens_d = tokens_q + 1'b1;
        end else if (qerr_view) begin
          err_d = qlt_pkg::ST_UNTERM;
        end
        phase_d = qlt_pkg::PH_DONE;
      end else if (room) begin
        case (phase_q)
          qlt_pkg::PH_BETWEEN: begin
            if (is_ws) begin
              phase_d = qlt_pkg::PH_BETWEEN;
            end else if (tokens_q == '0 && byte_i == qlt_pkg::CH_HASH) begin
              err_d   = qlt_pkg::ST_BLANK;
              phase_d = qlt_pkg::PH_DONE;
            end else if (tokens_q > qlt_pkg::TOK_MAX) begin
              err_d   = qlt_pkg::ST_TOO_MANY;
              phase_d = qlt_pkg::PH_DONE;
            end else if (byte_i == qlt_pkg::CH_QUOTE) begin
              phase_d = qlt_pkg::PH_QUOTE;
            end else begin
              phase_d = qlt_pkg::PH_PLAIN;
            end
          end
          qlt_pkg::PH_PLAIN: begin
            if (is_ws) begin
              tokens_d = tokens_q + 1'b1;
              phase_d  = qlt_pkg::PH_BETWEEN;
            end
          end
          qlt_pkg::PH_QUOTE: begin
            if (byte_i == qlt_pkg::CH_QUOTE) begin
              phase_d = qlt_pkg::PH_AFTERQ;
            end else if (byte_i == qlt_pkg::CH_BSLASH) begin
              phase_d = qlt_pkg::PH_BSLASH;
            end
          end
          qlt_pkg::PH_BSLASH: begin
            phase_d = qlt_pkg::PH_QUOTE;
          end
          qlt_pkg::PH_AFTERQ: begin
            if (is_ws) begin
              tokens_d = tokens_q + 1'b1;
              phase_d  = qlt_pkg::PH_BETWEEN;
            end else begin
              err_d   = qlt_pkg::ST_JUNK;
              phase_d = qlt_pkg::PH_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  // results
  logic [qlt_pkg::TOK_W-1:0] tok_after;
  qlt_pkg::status_e          st;
  logic [3:0]                argc;
  logic                      name;
  qlt_pkg::result_t          line_res;

  always_comb begin
    tok_after = tok_end_view ? tokens_q + 1'b1 : tokens_q;
    st        = qerr_view ? qlt_pkg::ST_UNTERM : err_q;
    if (st == qlt_pkg::ST_OK && tok_after == '0) begin
      st = qlt_pkg::ST_BLANK;
    end
    argc = '0;
    name = 1'b0;
    if (st == qlt_pkg::ST_OK) begin
      argc = 4'(tok_after - 1'b1);
      name = 1'b1;
    end else if ((st == qlt_pkg::ST_UNTERM || st == qlt_pkg::ST_JUNK) && tok_after != '0) begin
      name = 1'b1;
    end
    line_res = qlt_pkg::mk_line_end(st, argc, name, ovf_q);
  end

  always_comb begin
    res_o[0] = '0;
    res_o[1] = '0;
    n_o      = 2'd0;
    if (is_lf) begin
      if (tok_end_view) begin
        res_o[0] = qlt_pkg::mk_tok_end(tokens_q);
        res_o[1] = line_res;
        n_o      = 2'd2;
      end else begin
        res_o[0] = line_res;
        n_o      = 2'd1;
      end
    end else if (!is_cr) begin
      if ((room && byte_i == qlt_pkg::CH_NUL) || !room) begin
        if (tok_end_view) begin
          res_o[0] = qlt_pkg::mk_tok_end(tokens_q);
          n_o      = 2'd1;
        end
      end else begin
        case (phase_q)
          qlt_pkg::PH_BETWEEN: begin
            if (!is_ws && !(tokens_q == '0 && byte_i == qlt_pkg::CH_HASH) &&
                !(tokens_q > qlt_pkg::TOK_MAX) && byte_i != qlt_pkg::CH_QUOTE) begin
              res_o[0] = qlt_pkg::mk_char(byte_i, tokens_q);
              n_o      = 2'd1;
            end
          end
          qlt_pkg::PH_PLAIN: begin
            res_o[0] = is_ws ? qlt_pkg::mk_tok_end(tokens_q)
                             : qlt_pkg::mk_char(byte_i, tokens_q);
            n_o      = 2'd1;
          end
          qlt_pkg::PH_QUOTE: begin
            if (byte_i != qlt_pkg::CH_QUOTE && byte_i != qlt_pkg::CH_BSLASH) begin
              res_o[0] = qlt_pkg::mk_char(byte_i, tokens_q);
              n_o      = 2'd1;
            end
          end
          qlt_pkg::PH_BSLASH: begin
            if (byte_i == qlt_pkg::CH_QUOTE || byte_i == qlt_pkg::CH_BSLASH) begin
              res_o[0] = qlt_pkg::mk_char(byte_i, tokens_q);
              n_o      = 2'd1;
            end else begin
              // not an escape: the backslash stays literal
              res_o[0] = qlt_pkg::mk_char(qlt_pkg::CH_BSLASH, tokens_q);
              res_o[1] = qlt_pkg::mk_char(byte_i, tokens_q);
              n_o      = 2'd2;
            end
          end
          qlt_pkg::PH_AFTERQ: begin
            if (is_ws) begin
              res_o[0] = qlt_pkg::mk_tok_end(tokens_q);
              n_o      = 2'd1;
            end
          end
          default: begin
            n_o = 2'd0;
          end
        endcase
      end
    end
    if (n_o == 2'd1) begin
      res_o[0].last = 1'b1;
    end else if (n_o == 2'd2) begin
      res_o[1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= qlt_pkg::PH_BETWEEN;
      tokens_q <= '0;
      chars_q  <= '0;
      ovf_q    <= 1'b0;
      err_q    <= qlt_pkg::ST_OK;
    end else if (acc_i) begin
      phase_q  <= phase_d;
      tokens_q <= tokens_d;
      chars_q  <= chars_d;
      ovf_q    <= ovf_d;
      err_q    <= err_d;
    end
  end

  a_err_implies_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != qlt_pkg::ST_OK) |-> (phase_q == qlt_pkg::PH_DONE))
    else $error("line error recorded while still tokenizing");

  a_newline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && is_lf) |=> (phase_q == qlt_pkg::PH_BETWEEN && tokens_q == '0 && !ovf_q))
    else $error("line state not cleared after newline");

  a_tokens_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tokens_q <= qlt_pkg::TOK_MAX + 1'b1)
    else $error("completed token count beyond limit");

  a_last_marks_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_o == 2'd2) |-> (res_o[1].last && !res_o[0].last))
    else $error("last flag not on the final result");

endmodule

`default_nettype wire

// ===== rtl/core/quoted_line_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port group   Direction  Handshake              Payload
// input byte   in         in_valid_i/in_stall_o  byte_in_i
// result       out        out_valid_o/out_stall_i result_kind_o .. last_of_run_o
//
// A byte is decoded in the cycle it transfers; its 0 to 2 results land in a
// 4-entry result queue that drives the output ports from registers.
// One result leaves per cycle while out_stall_i is low, and bytes keep
// transferring while earlier results still wait in the queue.
// in_stall_o rises when fewer than two queue entries are free.
// Reset puts the tokenizer between tokens on an empty line and empties the queue.

module quoted_line_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      char_out_o,
  output logic [3:0]      token_index_o,
  output logic [2:0]      line_status_o,
  output logic [3:0]      arg_count_o,
  output logic            name_present_o,
  output logic            overflowed_o,
  output logic            last_of_run_o
);

  qlt_pkg::result_t [1:0]          res;
  logic [1:0]                      n;
  logic                            in_acc, out_acc;
  qlt_pkg::result_t                mem_q [qlt_pkg::FIFO_DEPTH];
  logic [qlt_pkg::PTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [qlt_pkg::CNT_W-1:0]       count_q, count_d;
  qlt_pkg::result_t                head;

  assign in_stall_o = (count_q > qlt_pkg::CNT_W'(qlt_pkg::FIFO_DEPTH - 2));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_acc    = out_valid_o && !out_stall_i;

  qlt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .byte_i (byte_in_i),
    .res_o  (res),
    .n_o    (n)
  );

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (in_acc) begin
      wr_ptr_d = wr_ptr_q + qlt_pkg::PTR_W'(n);
      count_d  = count_q + qlt_pkg::CNT_W'(n);
    end
    if (out_acc) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
      count_d  = count_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n != 2'd0) begin
      mem_q[wr_ptr_q] <= res[0];
    end
    if (in_acc && n == 2'd2) begin
      mem_q[wr_ptr_q + 1'b1] <= res[1];
    end
  end

  assign head           = mem_q[rd_ptr_q];
  assign result_kind_o  = head.kind;
  assign char_out_o     = head.ch;
  assign token_index_o  = head.idx;
  assign line_status_o  = head.status;
  assign arg_count_o    = head.argc;
  assign name_present_o = head.name;
  assign overflowed_o   = head.ovf;
  assign last_of_run_o  = head.last;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= qlt_pkg::CNT_W'(qlt_pkg::FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ((count_q + qlt_pkg::CNT_W'(n)) <= qlt_pkg::CNT_W'(qlt_pkg::FIFO_DEPTH)))
    else $error("byte transfer would overrun result queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != qlt_pkg::CNT_W'(qlt_pkg::FIFO_DEPTH)) |->
      (qlt_pkg::PTR_W'(wr_ptr_q - rd_ptr_q) == qlt_pkg::PTR_W'(count_q)))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire
